// ===== hw/rtl/eams_pkg.sv =====
package eams_pkg;

    localparam logic [1:0] MODE_QUEUE = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] CFG_SPEED  = 2'd0;
    localparam logic [1:0] CFG_EASE   = 2'd1;
    localparam logic [1:0] CFG_ANIM   = 2'd2;

    localparam logic [15:0] SPEED_RESET = 16'd256;

    localparam logic [16:0] PROG_ONE    = 17'h10000;
    localparam logic [49:0] ONE_Q48     = 50'h1_0000_0000_0000;
    localparam logic [17:0] THREE_Q16   = 18'd196608;
    localparam logic [17:0] BASE_90     = 18'd23040;
    localparam logic [17:0] BASE_180    = 18'd46080;
    localparam logic [50:0] ROUND_HALF  = 51'h0_0000_8000_0000;

    typedef enum logic [1:0] {
        EASE_SMOOTH = 2'd0,
        EASE_CUBIC  = 2'd1,
        EASE_BACK   = 2'd2,
        EASE_LINEAR = 2'd3
    } t_ease;

    typedef struct packed {
        logic [15:0] speed;
        t_ease       ease;
        logic        anim;
    } t_cfg;

    typedef struct packed {
        logic        is_queue;
        logic        is_tick;
        logic        is_clear;
        logic [7:0]  move_code;
        logic        is_double;
        logic        record;
        logic [15:0] delta;
    } t_cmd;

    typedef struct packed {
        logic        done_valid;
        logic [7:0]  done_move;
        logic        done_record;
        logic        animating;
        logic [15:0] angle;
        logic        dropped;
    } t_result;

endpackage

// ===== hw/rtl/eased_move_animation_sequencer_top.sv =====
// the back end takes one item at a time and accepts the next only after the last result
// is loaded into the output register; its sequencer runs the tick increment, the two
// easing products and the angle scaling through one shared multiplier
// a two-item command queue and an output register let either side stall on its own
// reset clears configuration, move queue count and pointers, the busy flag and progress;
// move queue memory contents are not cleared and are only read after being written
module eased_move_animation_sequencer_top #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int MOVE_CODE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // move_code[7:0], is_double[8], record_history[9], delta_time[25:10]
    input  logic [31:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // done_move[7:0], done_record[8], animating[9], angle[25:10], dropped[26]
    output logic [31:0] o_m_axis_tdata,
    // done_valid[0]
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    import eams_pkg::*;

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed <= SPEED_RESET;
            r_cfg.ease  <= EASE_SMOOTH;
            r_cfg.anim  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SPEED: r_cfg.speed <= i_cfg_data;
                CFG_EASE:  r_cfg.ease  <= t_ease'(i_cfg_data[1:0]);
                CFG_ANIM:  r_cfg.anim  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    eams_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    eams_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .MOVE_CODE_BITS(MOVE_CODE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_res_valid(o_m_axis_tvalid),
        .i_res_ready(i_m_axis_tready),
        .o_res      (w_res)
    );

    assign o_m_axis_tdata = {5'b0, w_res.dropped, w_res.angle, w_res.animating,
                             w_res.done_record, w_res.done_move};
    assign o_m_axis_tuser = w_res.done_valid;

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[25:10] <= 16'd47800))
        else $error("angle out of range");

    a_still_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[9]) |-> (o_m_axis_tdata[25:10] == 16'd0))
        else $error("angle shown while not animating");

    a_no_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[8:0] == 9'd0))
        else $error("completion fields set without completion");

    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |=> !w_cmd_pop)
        else $error("back end took two items in a row");

endmodule

// ===== hw/rtl/eams_ram.sv =====
module eams_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/eams_front.sv =====
module eams_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [31:0]     i_s_axis_tdata,
    input  logic [1:0]      i_s_axis_tuser,
    output logic            o_cmd_valid,
    output eams_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_pop
);

    import eams_pkg::*;

    t_cmd       w_in;
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_accept;

    // classify the item by its mode and unpack its data fields
    always_comb begin
        w_in.is_queue  = (i_s_axis_tuser == MODE_QUEUE);
        w_in.is_tick   = (i_s_axis_tuser == MODE_TICK);
        w_in.is_clear  = (i_s_axis_tuser == MODE_CLEAR);
        w_in.move_code = i_s_axis_tdata[7:0];
        w_in.is_double = i_s_axis_tdata[8];
        w_in.record    = i_s_axis_tdata[9];
        w_in.delta     = i_s_axis_tdata[25:10];
    end

    assign o_s_axis_tready = (r_cnt != 2'd2);
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign o_cmd_valid     = (r_cnt != 2'd0);
    assign o_cmd           = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_accept && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_accept && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_accept) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wp] <= w_in;
        end
    end

endmodule

// ===== hw/rtl/eams_back.sv =====
module eams_back #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int MOVE_CODE_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eams_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    input  eams_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output eams_pkg::t_result o_res
);

    import eams_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = MOVE_CODE_BITS + 2;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_EXEC = 10'b00_0000_0010,
        S_TICK = 10'b00_0000_0100,
        S_ADV  = 10'b00_0000_1000,
        S_POP  = 10'b00_0001_0000,
        S_E1   = 10'b00_0010_0000,
        S_E2   = 10'b00_0100_0000,
        S_E3   = 10'b00_1000_0000,
        S_OUT  = 10'b01_0000_0000,
        S_WAIT = 10'b10_0000_0000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_head;
    logic          r_busy;
    logic [16:0]   r_progress;
    logic          r_out_valid;

    t_cmd          r_cmd;
    logic [EW-1:0] r_active;
    logic [31:0]   r_prod;
    logic [32:0]   r_sq;
    logic [48:0]   r_cube;
    logic [50:0]   r_scaled;
    logic          r_done;
    logic [EW-1:0] r_done_entry;
    logic          r_dropped;
    t_result       r_out;

    logic [EW-1:0] w_new_entry;
    logic [EW-1:0] w_rdata;
    logic [PW:0]   w_tail_sum;
    logic [PW-1:0] w_tail;
    logic [PW-1:0] w_head_inc;
    logic          w_full;
    logic          w_we;
    logic          w_adv;
    logic [34:0]   w_prod5;
    logic [27:0]   w_np;
    logic          w_finish;
    logic [16:0]   w_t;
    logic [16:0]   w_v;
    logic [49:0]   w_e48;
    logic [32:0]   w_mul_a;
    logic [17:0]   w_mul_b;
    logic [50:0]   w_mul_p;
    logic [50:0]   w_rounded;
    logic          w_load;
    t_result       w_result;

    assign w_new_entry = {r_cmd.record, r_cmd.is_double, MOVE_CODE_BITS'(r_cmd.move_code)};

    // queue pointers, full flag and write and advance conditions
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_tail_sum = (PW + 1)'(r_head) + (PW + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= (PW + 1)'(QUEUE_DEPTH))
                      ? PW'(w_tail_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(w_tail_sum);
    assign w_head_inc = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign w_we       = (r_state == S_EXEC) && r_cmd.is_queue && !w_full;
    assign w_adv      = (r_cmd.is_queue || r_cmd.is_tick) && !r_busy && (r_count != '0)
                      && (i_cfg.anim || !r_done);

    eams_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_tail),
        .i_wdata(w_new_entry),
        .i_re   ((r_state == S_ADV) && w_adv),
        .i_raddr(r_head),
        .o_rdata(w_rdata)
    );

    // tick increment: delta * speed * 5 / 256
    assign w_prod5  = {1'b0, r_prod, 2'b00} + {3'b000, r_prod};
    assign w_np     = {1'b0, w_prod5[34:8]} + 28'(r_progress);
    assign w_finish = r_busy && (w_np >= 28'(PROG_ONE));

    assign w_t = r_progress;
    assign w_v = PROG_ONE - r_progress;

    always_comb begin
        unique case (i_cfg.ease)
            EASE_SMOOTH: w_e48 = 50'(r_cube);
            EASE_CUBIC:  w_e48 = ONE_Q48 - 50'(r_cube);
            EASE_BACK:   w_e48 = ONE_Q48 + {1'b0, r_sq, 16'b0} - {r_cube, 1'b0};
            EASE_LINEAR: w_e48 = {1'b0, w_t, 32'b0};
            default:     w_e48 = '0;
        endcase
    end

    // shared multiplier, operands chosen by step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_EXEC: begin
                w_mul_a = 33'(r_cmd.delta);
                w_mul_b = 18'(i_cfg.speed);
            end
            S_E1: begin
                w_mul_a = (i_cfg.ease == EASE_SMOOTH) ? 33'(w_t) : 33'(w_v);
                w_mul_b = (i_cfg.ease == EASE_SMOOTH) ? 18'(w_t) : 18'(w_v);
            end
            S_E2: begin
                w_mul_a = r_sq;
                w_mul_b = (i_cfg.ease == EASE_SMOOTH) ? (THREE_Q16 - {w_t, 1'b0}) : 18'(w_v);
            end
            S_E3: begin
                w_mul_a = w_e48[48:16];
                w_mul_b = r_active[MOVE_CODE_BITS] ? BASE_180 : BASE_90;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p   = w_mul_a * w_mul_b;
    assign w_rounded = r_scaled + ROUND_HALF;

    always_comb begin
        w_result.done_valid  = r_done;
        w_result.done_move   = r_done ? 8'(r_done_entry[MOVE_CODE_BITS-1:0]) : 8'd0;
        w_result.done_record = r_done & r_done_entry[MOVE_CODE_BITS+1];
        w_result.animating   = r_busy;
        w_result.angle       = r_busy ? w_rounded[47:32] : 16'd0;
        w_result.dropped     = r_dropped;
    end

    assign w_load    = (r_state == S_OUT) && (!r_out_valid || i_res_ready);
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = i_cmd_valid ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = r_cmd.is_tick ? S_TICK : S_ADV;
            S_TICK:  n_state = S_ADV;
            S_ADV:   n_state = w_adv ? S_POP : S_E1;
            S_POP:   n_state = S_E1;
            S_E1:    n_state = S_E2;
            S_E2:    n_state = S_E3;
            S_E3:    n_state = S_OUT;
            S_OUT:   n_state = w_load ? S_IDLE : S_WAIT;
            S_WAIT:  n_state = S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_busy      <= 1'b0;
            r_progress  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_EXEC: begin
                    if (w_we) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (r_cmd.is_clear) begin
                        r_count    <= '0;
                        r_head     <= '0;
                        r_busy     <= 1'b0;
                        r_progress <= '0;
                    end
                end
                S_TICK: begin
                    if (w_finish) begin
                        r_progress <= PROG_ONE;
                        r_busy     <= 1'b0;
                    end else if (r_busy) begin
                        r_progress <= w_np[16:0];
                    end
                end
                S_POP: begin
                    r_head  <= w_head_inc;
                    r_count <= r_count - CW'(1);
                    if (i_cfg.anim) begin
                        r_busy     <= 1'b1;
                        r_progress <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd        <= i_cmd;
                    r_done       <= 1'b0;
                    r_dropped    <= 1'b0;
                    r_done_entry <= '0;
                end
            end
            S_EXEC: begin
                r_prod <= w_mul_p[31:0];
                if (r_cmd.is_queue && w_full) begin
                    r_dropped <= 1'b1;
                end
            end
            S_TICK: begin
                if (w_finish) begin
                    r_done       <= 1'b1;
                    r_done_entry <= r_active;
                end
            end
            S_POP: begin
                if (i_cfg.anim) begin
                    r_active <= w_rdata;
                end else begin
                    r_done       <= 1'b1;
                    r_done_entry <= w_rdata;
                end
            end
            S_E1:    r_sq     <= w_mul_p[32:0];
            S_E2:    r_cube   <= w_mul_p[48:0];
            S_E3:    r_scaled <= w_mul_p;
            S_OUT: begin
                if (w_load) begin
                    r_out <= w_result;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
